@@ design/rcc_pkg.sv @@
// Package for the RGB colour classifier.
// Holds the shared widths, colour and register codes, reset values and the lane flag type.
// No dependencies; every other file of the block refers to it by scoped names.
package rcc_pkg;

  // Widths of the light level, the scaled level, the configuration port and the result word.
  localparam int LEVEL_W    = 16;
  localparam int SCALE_BITS = 8;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int OUT_W      = 32;

  localparam logic [LEVEL_W-1:0]    LEVEL_MAX = 16'hFFFF;
  localparam logic [SCALE_BITS-1:0] SCALE_TOP = 8'hFF;

  // Colour codes of the result word.
  typedef logic [2:0] colour_t;
  localparam colour_t COL_BLACK = 3'd0;
  localparam colour_t COL_RED   = 3'd1;
  localparam colour_t COL_GREEN = 3'd2;
  localparam colour_t COL_BLUE  = 3'd3;
  localparam colour_t COL_UNDEF = 3'd4;

  // Register indexes (byte address / 4).
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_WHITE_RED   = 3'd0;
  localparam reg_idx_t REG_WHITE_GREEN = 3'd1;
  localparam reg_idx_t REG_WHITE_BLUE  = 3'd2;
  localparam reg_idx_t REG_DARK_RED    = 3'd3;
  localparam reg_idx_t REG_DARK_GREEN  = 3'd4;
  localparam reg_idx_t REG_DARK_BLUE   = 3'd5;
  localparam reg_idx_t REG_BLACK_THR   = 3'd6;

  // Register reset values.
  localparam logic [LEVEL_W-1:0]    RST_WHITE      = 16'd0;
  localparam logic [LEVEL_W-1:0]    RST_DARK_RED   = 16'd90;
  localparam logic [LEVEL_W-1:0]    RST_DARK_GREEN = 16'd80;
  localparam logic [LEVEL_W-1:0]    RST_DARK_BLUE  = 16'd100;
  localparam logic [SCALE_BITS-1:0] RST_BLACK_THR  = 8'd30;

  // Status one lane reports along with its scaled level.
  typedef struct packed {
    logic tmo;
    logic clamp;
    logic badcal;
  } lane_flags_t;

endpackage

@@ design/rcc_lane.sv @@
// One colour channel of the classifier: a pipelined restoring divider that turns the
// pulse width into a light level, a calibration step and a second divider for 0..255.
// Depends on rcc_pkg.
module rcc_lane #(
  parameter int WIDTH_BITS = 20,
  parameter int FREQ_SCALE = 100000
) (
  input  logic                                                    clk,
  input  logic [$clog2(FREQ_SCALE+1)+rcc_pkg::SCALE_BITS:0]       adv,
  input  logic [WIDTH_BITS-1:0]                                   width,
  input  logic [rcc_pkg::LEVEL_W-1:0]                             dark,
  input  logic [rcc_pkg::LEVEL_W-1:0]                             white,
  output logic [rcc_pkg::SCALE_BITS-1:0]                          scaled,
  output rcc_pkg::lane_flags_t                                    flags
);

  localparam int QB = $clog2(FREQ_SCALE + 1);
  localparam int LW = rcc_pkg::LEVEL_W;
  localparam int SB = rcc_pkg::SCALE_BITS;
  localparam int PW = LW + SB;
  localparam logic [QB-1:0] NUM = QB'(FREQ_SCALE);

  // Level divider, one quotient bit per stage.
  logic [WIDTH_BITS-1:0] d_rem [QB];
  logic [WIDTH_BITS-1:0] d_div [QB];
  logic [QB-1:0]         d_quo [QB];
  logic                  d_tmo [QB];

  for (genvar k = 0; k < QB; k++) begin : g_lvl
    logic [WIDTH_BITS-1:0] rem_in;
    logic [WIDTH_BITS-1:0] div_in;
    logic [QB-1:0]         quo_in;
    logic                  tmo_in;
    logic [WIDTH_BITS:0]   trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign div_in = width;
      assign quo_in = '0;
      assign tmo_in = (width == '0);
    end else begin : g_next
      assign rem_in = d_rem[k-1];
      assign div_in = d_div[k-1];
      assign quo_in = d_quo[k-1];
      assign tmo_in = d_tmo[k-1];
    end

    // Bring down the next dividend bit and try a subtract.
    assign trial = {rem_in, NUM[QB-1-k]};
    assign ge    = (trial >= {1'b0, div_in});

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        d_rem[k] <= ge ? WIDTH_BITS'(trial - {1'b0, div_in}) : trial[WIDTH_BITS-1:0];
        d_div[k] <= div_in;
        d_quo[k] <= {quo_in[QB-2:0], ge};
        d_tmo[k] <= tmo_in;
      end
    end
  end

  // Saturate the level; a timed out width reads as full scale.
  logic [31:0]   qx;
  logic [LW-1:0] lv;
  assign qx = 32'(d_quo[QB-1]);
  assign lv = (d_tmo[QB-1] || (qx > 32'(rcc_pkg::LEVEL_MAX))) ? rcc_pkg::LEVEL_MAX : qx[LW-1:0];

  // Calibration step: distance from the dark offset times 255, compared with the span.
  logic          bad_c;
  logic          above;
  logic [LW-1:0] span_c;
  logic [LW-1:0] diff;
  logic [PW-1:0] prod;
  logic          sat_c;
  logic          low_c;

  assign bad_c  = (white <= dark);
  assign span_c = white - dark;
  assign above  = (lv >= dark);
  assign diff   = above ? (lv - dark) : (dark - lv);
  assign prod   = {diff, {SB{1'b0}}} - PW'(diff);
  assign sat_c  = above && (prod >= {span_c, {SB{1'b0}}});
  assign low_c  = !above && (prod >= PW'(span_c));

  logic [PW-1:0] m_num;
  logic [LW-1:0] m_span;
  logic          m_sat;
  logic          m_low;
  logic          m_bad;
  logic          m_tmo;

  always_ff @(posedge clk) begin
    if (adv[QB]) begin
      m_num  <= above ? prod : '0;
      m_span <= span_c;
      m_sat  <= sat_c;
      m_low  <= low_c;
      m_bad  <= bad_c;
      m_tmo  <= d_tmo[QB-1];
    end
  end

  // Scale divider, one bit per stage: the quotient fits in SB bits unless the saturation flag is set.
  logic [PW-1:0] e_rem  [SB];
  logic [SB-1:0] e_quo  [SB];
  logic [LW-1:0] e_span [SB];
  logic          e_sat  [SB];
  logic          e_low  [SB];
  logic          e_bad  [SB];
  logic          e_tmo  [SB];

  for (genvar j = 0; j < SB; j++) begin : g_scl
    logic [PW-1:0] rem_in;
    logic [SB-1:0] quo_in;
    logic [LW-1:0] span_in;
    logic          sat_in;
    logic          low_in;
    logic          bad_in;
    logic          tmo_in;
    logic [PW-1:0] shifted;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in  = m_num;
      assign quo_in  = '0;
      assign span_in = m_span;
      assign sat_in  = m_sat;
      assign low_in  = m_low;
      assign bad_in  = m_bad;
      assign tmo_in  = m_tmo;
    end else begin : g_next
      assign rem_in  = e_rem[j-1];
      assign quo_in  = e_quo[j-1];
      assign span_in = e_span[j-1];
      assign sat_in  = e_sat[j-1];
      assign low_in  = e_low[j-1];
      assign bad_in  = e_bad[j-1];
      assign tmo_in  = e_tmo[j-1];
    end

    assign shifted = PW'(span_in) << (SB - 1 - j);
    assign ge      = (rem_in >= shifted);

    always_ff @(posedge clk) begin
      if (adv[QB+1+j]) begin
        e_rem[j]  <= ge ? (rem_in - shifted) : rem_in;
        e_quo[j]  <= {quo_in[SB-2:0], ge};
        e_span[j] <= span_in;
        e_sat[j]  <= sat_in;
        e_low[j]  <= low_in;
        e_bad[j]  <= bad_in;
        e_tmo[j]  <= tmo_in;
      end
    end
  end

  // Clamp and report.
  assign scaled       = e_bad[SB-1] ? '0 : (e_sat[SB-1] ? rcc_pkg::SCALE_TOP : e_quo[SB-1]);
  assign flags.tmo    = e_tmo[SB-1];
  assign flags.clamp  = !e_bad[SB-1] && (e_sat[SB-1] || e_low[SB-1]);
  assign flags.badcal = e_bad[SB-1];

endmodule

@@ design/rcc_merge.sv @@
// Merging stage of the classifier: combines the three lane results into a colour
// decision and holds the finished result word. Depends on rcc_pkg.
module rcc_merge (
  input  logic                            clk,
  input  logic                            load,
  input  logic [rcc_pkg::SCALE_BITS-1:0]  red_in,
  input  logic [rcc_pkg::SCALE_BITS-1:0]  green_in,
  input  logic [rcc_pkg::SCALE_BITS-1:0]  blue_in,
  input  rcc_pkg::lane_flags_t            red_flags,
  input  rcc_pkg::lane_flags_t            green_flags,
  input  rcc_pkg::lane_flags_t            blue_flags,
  input  logic [rcc_pkg::SCALE_BITS-1:0]  black_threshold,
  output rcc_pkg::colour_t                colour,
  output logic [rcc_pkg::SCALE_BITS-1:0]  red_scaled,
  output logic [rcc_pkg::SCALE_BITS-1:0]  green_scaled,
  output logic [rcc_pkg::SCALE_BITS-1:0]  blue_scaled,
  output logic                            timed_out,
  output logic                            clamped,
  output logic                            calibration_bad
);

  localparam int SB = rcc_pkg::SCALE_BITS;

  logic [SB+1:0]    sum;
  logic [SB+1:0]    thr3;
  logic [SB:0]      gb;
  logic [SB:0]      rb;
  logic [SB:0]      rg;
  logic             tmo;
  logic             red_win;
  logic             green_win;
  logic             blue_win;
  rcc_pkg::colour_t colour_c;

  assign tmo  = red_flags.tmo | green_flags.tmo | blue_flags.tmo;
  assign sum  = (SB+2)'(red_in) + (SB+2)'(green_in) + (SB+2)'(blue_in);
  assign thr3 = (SB+2)'({black_threshold, 1'b0}) + (SB+2)'(black_threshold);
  assign gb   = (SB+1)'(green_in) + (SB+1)'(blue_in);
  assign rb   = (SB+1)'(red_in) + (SB+1)'(blue_in);
  assign rg   = (SB+1)'(red_in) + (SB+1)'(green_in);

  // A channel wins when four times it exceeds three times the other two.
  assign red_win   = (SB+3)'({red_in, 2'b00})   > ((SB+3)'({gb, 1'b0}) + (SB+3)'(gb));
  assign green_win = (SB+3)'({green_in, 2'b00}) > ((SB+3)'({rb, 1'b0}) + (SB+3)'(rb));
  assign blue_win  = (SB+3)'({blue_in, 2'b00})  > ((SB+3)'({rg, 1'b0}) + (SB+3)'(rg));

  // Decision order: timeout, black, red, green, blue.
  always_comb begin
    if (tmo) begin
      colour_c = rcc_pkg::COL_UNDEF;
    end else if (sum < thr3) begin
      colour_c = rcc_pkg::COL_BLACK;
    end else if (red_win) begin
      colour_c = rcc_pkg::COL_RED;
    end else if (green_win) begin
      colour_c = rcc_pkg::COL_GREEN;
    end else if (blue_win) begin
      colour_c = rcc_pkg::COL_BLUE;
    end else begin
      colour_c = rcc_pkg::COL_UNDEF;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      colour          <= colour_c;
      red_scaled      <= red_in;
      green_scaled    <= green_in;
      blue_scaled     <= blue_in;
      timed_out       <= tmo;
      clamped         <= red_flags.clamp | green_flags.clamp | blue_flags.clamp;
      calibration_bad <= red_flags.badcal | green_flags.badcal | blue_flags.badcal;
    end
  end

endmodule

@@ design/rgb_colour_classifier.sv @@
// Top level of the RGB colour classifier: configuration registers, pipeline flow
// control, three channel lanes and the merging stage. Depends on rcc_pkg, rcc_lane
// and rcc_merge.
//
// Usage: each input word on s_tdata carries the red, green and blue pulse widths.
// Each width is turned into a light level (FREQ_SCALE / width, saturated at 65535),
// mapped onto 0..255 between the dark and white calibration registers and the
// colour is decided from the three scaled levels. One result word on m_tdata
// follows every input word, in order.
// The pipeline holds a stage for each quotient bit of the level divider, a calibration
// stage, a stage for each bit of the scale divider and the result register. The lanes
// are fully pipelined, so a new word is taken every cycle unless every stage holds a
// word and the receiver stalls. Each pipeline stage holds its own valid bit; a stalled
// receiver fills the empty stages first, and s_tready only drops once every stage
// holds a word. Reset clears the valid bits and loads the register reset values.
// The user must write the registers through the APB port only while no word is in
// flight; the block itself does not enforce this.
module rgb_colour_classifier #(
  parameter int WIDTH_BITS = 20,
  parameter int FREQ_SCALE = 100000
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // s_tdata: red_width, green_width, blue_width, then zero padding
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [8*((3*WIDTH_BITS+7)/8)-1:0]        s_tdata,
  // m_tdata: colour[2:0], red_scaled, green_scaled, blue_scaled, timed_out,
  // clamped, calibration_bad, then zero padding
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [rcc_pkg::OUT_W-1:0]                m_tdata,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [rcc_pkg::ADDR_W-1:0]               paddr,
  input  logic [rcc_pkg::DATA_W-1:0]               pwdata,
  output logic [rcc_pkg::DATA_W-1:0]               prdata,
  output logic                                     pready
);

  localparam int QB = $clog2(FREQ_SCALE + 1);
  localparam int NL = QB + 1 + rcc_pkg::SCALE_BITS;
  localparam int NS = NL + 1;
  localparam int LW = rcc_pkg::LEVEL_W;
  localparam int SB = rcc_pkg::SCALE_BITS;

  // Configuration registers.
  logic [LW-1:0] white_red;
  logic [LW-1:0] white_green;
  logic [LW-1:0] white_blue;
  logic [LW-1:0] dark_red;
  logic [LW-1:0] dark_green;
  logic [LW-1:0] dark_blue;
  logic [SB-1:0] black_threshold;

  rcc_pkg::reg_idx_t reg_idx;
  assign reg_idx = paddr[rcc_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_red       <= rcc_pkg::RST_WHITE;
      white_green     <= rcc_pkg::RST_WHITE;
      white_blue      <= rcc_pkg::RST_WHITE;
      dark_red        <= rcc_pkg::RST_DARK_RED;
      dark_green      <= rcc_pkg::RST_DARK_GREEN;
      dark_blue       <= rcc_pkg::RST_DARK_BLUE;
      black_threshold <= rcc_pkg::RST_BLACK_THR;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        rcc_pkg::REG_WHITE_RED:   white_red       <= pwdata[LW-1:0];
        rcc_pkg::REG_WHITE_GREEN: white_green     <= pwdata[LW-1:0];
        rcc_pkg::REG_WHITE_BLUE:  white_blue      <= pwdata[LW-1:0];
        rcc_pkg::REG_DARK_RED:    dark_red        <= pwdata[LW-1:0];
        rcc_pkg::REG_DARK_GREEN:  dark_green      <= pwdata[LW-1:0];
        rcc_pkg::REG_DARK_BLUE:   dark_blue       <= pwdata[LW-1:0];
        rcc_pkg::REG_BLACK_THR:   black_threshold <= pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      rcc_pkg::REG_WHITE_RED:   prdata = rcc_pkg::DATA_W'(white_red);
      rcc_pkg::REG_WHITE_GREEN: prdata = rcc_pkg::DATA_W'(white_green);
      rcc_pkg::REG_WHITE_BLUE:  prdata = rcc_pkg::DATA_W'(white_blue);
      rcc_pkg::REG_DARK_RED:    prdata = rcc_pkg::DATA_W'(dark_red);
      rcc_pkg::REG_DARK_GREEN:  prdata = rcc_pkg::DATA_W'(dark_green);
      rcc_pkg::REG_DARK_BLUE:   prdata = rcc_pkg::DATA_W'(dark_blue);
      rcc_pkg::REG_BLACK_THR:   prdata = rcc_pkg::DATA_W'(black_threshold);
      default:                  prdata = '0;
    endcase
  end

  // Per-stage valid bits; a stage loads when it is empty or its successor moves on.
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];

  // Channel lanes.
  logic [SB-1:0]        red_lvl;
  logic [SB-1:0]        green_lvl;
  logic [SB-1:0]        blue_lvl;
  rcc_pkg::lane_flags_t red_flags;
  rcc_pkg::lane_flags_t green_flags;
  rcc_pkg::lane_flags_t blue_flags;

  rcc_lane #(.WIDTH_BITS(WIDTH_BITS), .FREQ_SCALE(FREQ_SCALE)) u_lane_red (
    .clk    (clk),
    .adv    (rdy[NL-1:0]),
    .width  (s_tdata[WIDTH_BITS-1:0]),
    .dark   (dark_red),
    .white  (white_red),
    .scaled (red_lvl),
    .flags  (red_flags)
  );

  rcc_lane #(.WIDTH_BITS(WIDTH_BITS), .FREQ_SCALE(FREQ_SCALE)) u_lane_green (
    .clk    (clk),
    .adv    (rdy[NL-1:0]),
    .width  (s_tdata[2*WIDTH_BITS-1:WIDTH_BITS]),
    .dark   (dark_green),
    .white  (white_green),
    .scaled (green_lvl),
    .flags  (green_flags)
  );

  rcc_lane #(.WIDTH_BITS(WIDTH_BITS), .FREQ_SCALE(FREQ_SCALE)) u_lane_blue (
    .clk    (clk),
    .adv    (rdy[NL-1:0]),
    .width  (s_tdata[3*WIDTH_BITS-1:2*WIDTH_BITS]),
    .dark   (dark_blue),
    .white  (white_blue),
    .scaled (blue_lvl),
    .flags  (blue_flags)
  );

  // Merge and result register.
  rcc_pkg::colour_t colour;
  logic [SB-1:0]    red_scaled;
  logic [SB-1:0]    green_scaled;
  logic [SB-1:0]    blue_scaled;
  logic             timed_out;
  logic             clamped;
  logic             calibration_bad;

  rcc_merge u_merge (
    .clk             (clk),
    .load            (rdy[NS-1]),
    .red_in          (red_lvl),
    .green_in        (green_lvl),
    .blue_in         (blue_lvl),
    .red_flags       (red_flags),
    .green_flags     (green_flags),
    .blue_flags      (blue_flags),
    .black_threshold (black_threshold),
    .colour          (colour),
    .red_scaled      (red_scaled),
    .green_scaled    (green_scaled),
    .blue_scaled     (blue_scaled),
    .timed_out       (timed_out),
    .clamped         (clamped),
    .calibration_bad (calibration_bad)
  );

  assign m_tdata = rcc_pkg::OUT_W'({calibration_bad, clamped, timed_out,
                                    blue_scaled, green_scaled, red_scaled, colour});

endmodule

@@ design/rcc_checker.sv @@
// Port-level checker for the RGB colour classifier and the bind that attaches it.
// Depends on rcc_pkg and on the top level rgb_colour_classifier.
module rcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rcc_pkg::OUT_W-1:0]     m_tdata
);

  rcc_pkg::colour_t colour;
  logic [7:0]       red_scaled;
  logic [7:0]       green_scaled;
  logic             timed_out;

  assign colour       = m_tdata[2:0];
  assign red_scaled   = m_tdata[10:3];
  assign green_scaled = m_tdata[18:11];
  assign timed_out    = m_tdata[27];

  // No result word survives a reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // A stalled result word stays in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // A timed out measurement is never classified.
  a_timeout_undef: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && timed_out |-> colour == rcc_pkg::COL_UNDEF)
    else $error("timed out word carries a colour");

  // A winning red or green channel cannot have a zero level.
  a_red_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && colour == rcc_pkg::COL_RED |-> red_scaled != 8'd0)
    else $error("red decision with zero red level");

  a_green_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && colour == rcc_pkg::COL_GREEN |-> green_scaled != 8'd0)
    else $error("green decision with zero green level");

endmodule

bind rgb_colour_classifier rcc_checker u_rcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ test/rcc_checker.sv @@
// Scoreboard for the RGB colour classifier: mirrors the calibration registers from the
// APB bus, predicts one result word per accepted input word and compares field by field.
// Depends on rcc_pkg for the widths, colour codes, register indexes and reset values.
`timescale 1ns / 1ps

module rcc_scoreboard #(
  parameter int WIDTH_BITS = 20,
  parameter int FREQ_SCALE = 100000,
  parameter int S_W        = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // s_tdata: red_width, green_width, blue_width, then zero padding
  input  logic [S_W-1:0]              s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // m_tdata: colour, red_scaled, green_scaled, blue_scaled, timed_out, clamped,
  // calibration_bad, then zero padding
  input  logic [rcc_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [rcc_pkg::DATA_W-1:0]  pwdata,
  input  logic [rcc_pkg::DATA_W-1:0]  prdata,
  input  logic                        pready,
  output int unsigned                 pending,
  output int unsigned                 errors,
  output int unsigned                 compared
);

  localparam int LW = rcc_pkg::LEVEL_W;
  localparam int SB = rcc_pkg::SCALE_BITS;

  // One classified reading as the block reports it.
  typedef struct packed {
    rcc_pkg::colour_t  colour;
    logic [SB-1:0]     red;
    logic [SB-1:0]     green;
    logic [SB-1:0]     blue;
    logic              timed_out;
    logic              clamped;
    logic              cal_bad;
  } reading_t;

  // Shadow copy of the calibration registers, indexed like the register map.
  logic [LW-1:0]      cal_reg [0:6];
  reading_t           readings_due [$];
  reading_t           got_reading;
  reading_t           due_reading;
  rcc_pkg::reg_idx_t  cfg_idx;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Light level from a pulse width: the divider saturates, and a zero width is a timeout.
  function automatic logic [LW-1:0] pulse_to_level(input logic [WIDTH_BITS-1:0] w,
                                                   inout logic tmo);
    int unsigned wv;
    int unsigned quot;
    wv = w;
    if (wv == 0) begin
      tmo = 1'b1;
      return rcc_pkg::LEVEL_MAX;
    end
    quot = int'(FREQ_SCALE) / wv;
    return (quot > rcc_pkg::LEVEL_MAX) ? rcc_pkg::LEVEL_MAX : LW'(quot);
  endfunction

  // Linear map of a level from [dark, white] onto 0..255 with clamping.
  function automatic logic [SB-1:0] calibrate(input logic [LW-1:0] lvl,
                                              input logic [LW-1:0] dark,
                                              input logic [LW-1:0] white,
                                              inout logic clp, inout logic bad);
    int unsigned span;
    int unsigned quot;
    if (white <= dark) begin
      bad = 1'b1;
      return '0;
    end
    span = white - dark;
    if (lvl >= dark) begin
      quot = ((lvl - dark) * 255) / span;
      if (quot > rcc_pkg::SCALE_TOP) begin
        clp = 1'b1;
        return rcc_pkg::SCALE_TOP;
      end
      return SB'(quot);
    end
    quot = ((dark - lvl) * 255) / span;
    if (quot != 0) clp = 1'b1;
    return '0;
  endfunction

  function automatic reading_t predict_reading(input logic [S_W-1:0] word);
    reading_t       res;
    logic [LW-1:0]  lr, lg, lb;
    logic           tmo, clp, bad;
    int unsigned    sr, sg, sb;
    tmo = 1'b0;
    clp = 1'b0;
    bad = 1'b0;
    lr = pulse_to_level(word[WIDTH_BITS-1:0], tmo);
    lg = pulse_to_level(word[2*WIDTH_BITS-1:WIDTH_BITS], tmo);
    lb = pulse_to_level(word[3*WIDTH_BITS-1:2*WIDTH_BITS], tmo);
    res.red   = calibrate(lr, cal_reg[rcc_pkg::REG_DARK_RED],
                          cal_reg[rcc_pkg::REG_WHITE_RED], clp, bad);
    res.green = calibrate(lg, cal_reg[rcc_pkg::REG_DARK_GREEN],
                          cal_reg[rcc_pkg::REG_WHITE_GREEN], clp, bad);
    res.blue  = calibrate(lb, cal_reg[rcc_pkg::REG_DARK_BLUE],
                          cal_reg[rcc_pkg::REG_WHITE_BLUE], clp, bad);
    sr = res.red;
    sg = res.green;
    sb = res.blue;
    // A timeout overrides every other decision; the channel tests run in fixed order.
    if (tmo) res.colour = rcc_pkg::COL_UNDEF;
    else if (sr + sg + sb < 3 * cal_reg[rcc_pkg::REG_BLACK_THR]) res.colour = rcc_pkg::COL_BLACK;
    else if (4 * sr > 3 * (sg + sb)) res.colour = rcc_pkg::COL_RED;
    else if (4 * sg > 3 * (sr + sb)) res.colour = rcc_pkg::COL_GREEN;
    else if (4 * sb > 3 * (sr + sg)) res.colour = rcc_pkg::COL_BLUE;
    else res.colour = rcc_pkg::COL_UNDEF;
    res.timed_out = tmo;
    res.clamped   = clp;
    res.cal_bad   = bad;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cal_reg[rcc_pkg::REG_WHITE_RED]   = rcc_pkg::RST_WHITE;
      cal_reg[rcc_pkg::REG_WHITE_GREEN] = rcc_pkg::RST_WHITE;
      cal_reg[rcc_pkg::REG_WHITE_BLUE]  = rcc_pkg::RST_WHITE;
      cal_reg[rcc_pkg::REG_DARK_RED]    = rcc_pkg::RST_DARK_RED;
      cal_reg[rcc_pkg::REG_DARK_GREEN]  = rcc_pkg::RST_DARK_GREEN;
      cal_reg[rcc_pkg::REG_DARK_BLUE]   = rcc_pkg::RST_DARK_BLUE;
      cal_reg[rcc_pkg::REG_BLACK_THR]   = {8'h00, rcc_pkg::RST_BLACK_THR};
      readings_due.delete();
    end else begin
      // Register writes update the shadow copy; reads are checked against it.
      if (psel && penable && pready) begin
        cfg_idx = paddr[rcc_pkg::ADDR_W-1:2];
        if (pwrite) begin
          if (cfg_idx == rcc_pkg::REG_BLACK_THR) cal_reg[cfg_idx] = {8'h00, pwdata[7:0]};
          else if (cfg_idx < rcc_pkg::REG_BLACK_THR) cal_reg[cfg_idx] = pwdata[LW-1:0];
        end else if (cfg_idx <= rcc_pkg::REG_BLACK_THR &&
                     prdata !== rcc_pkg::DATA_W'(cal_reg[cfg_idx])) begin
          report_mismatch("register readback", prdata, cal_reg[cfg_idx]);
        end
      end

      // Each result word is matched against the oldest outstanding prediction.
      if (m_tvalid && m_tready) begin
        compared++;
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected result word", m_tdata, 0);
        end else begin
          due_reading           = readings_due.pop_front();
          got_reading.colour    = m_tdata[2:0];
          got_reading.red       = m_tdata[10:3];
          got_reading.green     = m_tdata[18:11];
          got_reading.blue      = m_tdata[26:19];
          got_reading.timed_out = m_tdata[27];
          got_reading.clamped   = m_tdata[28];
          got_reading.cal_bad   = m_tdata[29];
          if (got_reading.colour !== due_reading.colour)
            report_mismatch("colour", got_reading.colour, due_reading.colour);
          if (got_reading.red !== due_reading.red)
            report_mismatch("red_scaled", got_reading.red, due_reading.red);
          if (got_reading.green !== due_reading.green)
            report_mismatch("green_scaled", got_reading.green, due_reading.green);
          if (got_reading.blue !== due_reading.blue)
            report_mismatch("blue_scaled", got_reading.blue, due_reading.blue);
          if (got_reading.timed_out !== due_reading.timed_out)
            report_mismatch("timed_out", got_reading.timed_out, due_reading.timed_out);
          if (got_reading.clamped !== due_reading.clamped)
            report_mismatch("clamped", got_reading.clamped, due_reading.clamped);
          if (got_reading.cal_bad !== due_reading.cal_bad)
            report_mismatch("calibration_bad", got_reading.cal_bad, due_reading.cal_bad);
          if (m_tdata[rcc_pkg::OUT_W-1:30] !== '0)
            report_mismatch("result padding", m_tdata[rcc_pkg::OUT_W-1:30], 0);
        end
      end

      if (s_tvalid && s_tready) readings_due.push_back(predict_reading(s_tdata));
    end
    pending = readings_due.size();
  end

endmodule

@@ test/tb_rgb_colour_classifier.sv @@
// Testbench top for the RGB colour classifier: clock, reset, stream and APB stimulus
// under several calibration settings, and the final verdict.
// Depends on rcc_pkg, the rgb_colour_classifier RTL and the rcc_scoreboard checker.
`timescale 1ns / 1ps

module tb_rgb_colour_classifier;

  localparam int WIDTH_BITS = 20;
  localparam int FREQ_SCALE = 100000;
  localparam int S_W        = 8 * ((3 * WIDTH_BITS + 7) / 8);
  localparam int PHASE_LEN  = 122;
  localparam int HOLD_AT    = 420;
  localparam int HOLD_LEN   = 300;
  localparam int LW         = rcc_pkg::LEVEL_W;
  localparam int DW         = rcc_pkg::DATA_W;
  // Address one past the register map; writes there must have no effect.
  localparam rcc_pkg::reg_idx_t REG_SPARE = 3'd7;

  typedef enum int {AIM_WIDE, AIM_HOT, AIM_COLD} aim_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  // s_tdata: red_width, green_width, blue_width, then zero padding
  logic [S_W-1:0]               s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  // m_tdata: colour, red_scaled, green_scaled, blue_scaled, timed_out, clamped,
  // calibration_bad, then zero padding
  logic [rcc_pkg::OUT_W-1:0]    m_tdata;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rcc_pkg::ADDR_W-1:0]   paddr;
  logic [DW-1:0]                pwdata;
  logic [DW-1:0]                prdata;
  logic                         pready;

  int unsigned        pending;
  int unsigned        mismatches;
  int unsigned        compared;
  int unsigned        words_sent = 0;
  int unsigned        settings_used = 0;
  bit                 steady = 1'b0;
  bit                 held = 1'b0;
  logic [LW-1:0]      cfg_white [0:2];
  logic [LW-1:0]      cfg_dark [0:2];

  rgb_colour_classifier #(
    .WIDTH_BITS(WIDTH_BITS),
    .FREQ_SCALE(FREQ_SCALE)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rcc_scoreboard #(
    .WIDTH_BITS(WIDTH_BITS),
    .FREQ_SCALE(FREQ_SCALE),
    .S_W(S_W)
  ) scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pending(pending), .errors(mismatches), .compared(compared)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short idle stretches with a few long ones; none at all in steady phases.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pulse width aimed at a part of the calibration window, with some timeouts,
  // raw 20-bit patterns and very short widths mixed in.
  function automatic logic [WIDTH_BITS-1:0] pick_width(input logic [LW-1:0] dk,
                                                       input logic [LW-1:0] wh,
                                                       input aim_t aim);
    int r, lo, hi, span, a, b, lvl;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 13) return WIDTH_BITS'($urandom());
    if (r < 18) return WIDTH_BITS'($urandom_range(1, 60));
    lo = (dk < wh) ? int'(dk) : int'(wh);
    hi = (dk < wh) ? int'(wh) : int'(dk);
    span = hi - lo + 1;
    case (aim)
      AIM_HOT: begin
        a = hi - span / 2;
        b = hi + span / 4;
      end
      AIM_COLD: begin
        a = lo - span / 4;
        b = lo + span / 3;
      end
      default: begin
        a = lo - span / 4;
        b = hi + span / 4;
      end
    endcase
    if (a < 1) a = 1;
    if (b < 1) b = 1;
    if (a > 65535) a = 65535;
    if (b > 65535) b = 65535;
    lvl = a + int'($urandom_range(0, b - a));
    return WIDTH_BITS'(FREQ_SCALE / lvl);
  endfunction

  // Offers one word and returns at the falling edge after it was taken.
  task automatic send_word(input logic [WIDTH_BITS-1:0] r, input logic [WIDTH_BITS-1:0] g,
                           input logic [WIDTH_BITS-1:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_W'({b, g, r});
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_word();
    int style;
    aim_t aim [0:2];
    style = $urandom_range(0, 3);
    for (int ch = 0; ch < 3; ch++)
      aim[ch] = (style == 0) ? AIM_WIDE : ((style - 1 == ch) ? AIM_HOT : AIM_COLD);
    send_word(pick_width(cfg_dark[0], cfg_white[0], aim[0]),
              pick_width(cfg_dark[1], cfg_white[1], aim[1]),
              pick_width(cfg_dark[2], cfg_white[2], aim[2]));
  endtask

  // Stops offering and waits until every word in flight has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_access(input rcc_pkg::reg_idx_t idx, input bit wr,
                            input logic [DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Writes a full calibration set, then reads every register back.
  task automatic calibrate_sensor(input logic [DW-1:0] wr, input logic [DW-1:0] wg,
                                  input logic [DW-1:0] wb, input logic [DW-1:0] dr,
                                  input logic [DW-1:0] dg, input logic [DW-1:0] db,
                                  input logic [DW-1:0] thr);
    apb_access(rcc_pkg::REG_WHITE_RED, 1'b1, wr);
    apb_access(rcc_pkg::REG_WHITE_GREEN, 1'b1, wg);
    apb_access(rcc_pkg::REG_WHITE_BLUE, 1'b1, wb);
    apb_access(rcc_pkg::REG_DARK_RED, 1'b1, dr);
    apb_access(rcc_pkg::REG_DARK_GREEN, 1'b1, dg);
    apb_access(rcc_pkg::REG_DARK_BLUE, 1'b1, db);
    apb_access(rcc_pkg::REG_BLACK_THR, 1'b1, thr);
    cfg_white[0] = wr[LW-1:0];
    cfg_white[1] = wg[LW-1:0];
    cfg_white[2] = wb[LW-1:0];
    cfg_dark[0]  = dr[LW-1:0];
    cfg_dark[1]  = dg[LW-1:0];
    cfg_dark[2]  = db[LW-1:0];
    for (int i = 0; i <= rcc_pkg::REG_BLACK_THR; i++)
      apb_access(rcc_pkg::reg_idx_t'(i), 1'b0, '0);
    settings_used++;
  endtask

  // Result side: random back-pressure plus one long hold while the sender keeps going.
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && words_sent >= HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        held = 1'b1;
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout: the classifier stopped making progress");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset calibration: every white level is below its dark offset.
    for (int i = 0; i <= rcc_pkg::REG_BLACK_THR; i++)
      apb_access(rcc_pkg::reg_idx_t'(i), 1'b0, '0);
    send_word(20'd200, 20'd300, 20'd400);
    send_word(20'd1, 20'd0, 20'hFFFFF);
    drain();

    // Window of levels 100..1000 on every channel, threshold 30.
    calibrate_sensor(1000, 1000, 1000, 100, 100, 100, 30);
    apb_access(REG_SPARE, 1'b1, 32'hFFFF_FFFF);
    apb_access(rcc_pkg::REG_DARK_RED, 1'b0, '0);
    send_word(20'd0, 20'd0, 20'd0);
    send_word(20'd0, 20'd200, 20'd200);
    send_word(20'd200, 20'd200, 20'd0);
    send_word(20'd100, 20'd1000, 20'd0);
    send_word(20'd1, 20'd1, 20'd1);
    send_word(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    // Level just under the dark offset: truncates to zero without clamping.
    send_word(20'd1030, 20'd1030, 20'd1030);
    // Scaled sum exactly at, then just under, three times the threshold.
    send_word(20'd485, 20'd485, 20'd485);
    send_word(20'd486, 20'd486, 20'd486);
    send_word(20'd100, 20'd1000, 20'd1000);
    send_word(20'd1000, 20'd100, 20'd1000);
    send_word(20'd1000, 20'd1000, 20'd100);
    send_word(20'd100, 20'd100, 20'd100);
    send_word(20'd200, 20'd200, 20'd200);
    send_word(20'd99, 20'd101, 20'd1000);
    send_word(20'd2, 20'd3, 20'd4);
    send_word(20'hAAAAA, 20'h55555, 20'hFFFFE);
    drain();

    // Full-range red, white equal to dark on green, blue at the top of both.
    calibrate_sensor(65535, 500, 65535, 0, 500, 65535, 255);
    send_word(20'd1, 20'd1, 20'd1);
    send_word(20'd100, 20'd200, 20'd300);
    send_word(20'hFFFFF, 20'd1, 20'd0);
    send_word(20'd1, 20'hFFFFF, 20'hFFFFF);
    drain();

    // Random readings under a sequence of calibrations.
    for (int phase = 0; phase < 6; phase++) begin
      steady = (phase == 4);
      case (phase)
        0: calibrate_sensor(1000, 1200, 800, 100, 50, 150, 30);
        1: calibrate_sensor(65535, 65535, 65535, 0, 0, 0, 0);
        2: calibrate_sensor(65535, 401, 300, 65535, 400, 0, 255);
        4: calibrate_sensor(300, 250, 350, 0, 10, 5, 10);
        default: calibrate_sensor($urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom());
      endcase
      repeat (PHASE_LEN) send_random_word();
      drain();
    end
    steady = 1'b0;

    // Let anything stray come out before the verdict.
    repeat (40) @(posedge clk);
    $display("Sent %0d readings under %0d calibration settings; %0d results compared.",
             words_sent, settings_used, compared);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rcc_pkg.sv
design/rcc_lane.sv
design/rcc_merge.sv
design/rgb_colour_classifier.sv
design/rcc_checker.sv
test/rcc_checker.sv
test/tb_rgb_colour_classifier.sv
